>>> rtl/core/edh_pkg.sv
package edh_pkg;

   // sizes fixed by the stream and register formats
   localparam int GRAY_W         = 8;
   localparam int ROW_LENGTH_W   = 12;
   localparam int ROW_COUNT_W    = 16;
   localparam int THRESHOLD_W    = 8;

   // line store geometry and error precision
   localparam int MAX_ROW_LENGTH = 2048;
   localparam int ERROR_BITS     = 12;
   localparam int ADDR_W         = $clog2(MAX_ROW_LENGTH);
   localparam int LEN_W          = ($clog2(MAX_ROW_LENGTH + 1) > ROW_LENGTH_W) ?
                                   $clog2(MAX_ROW_LENGTH + 1) : ROW_LENGTH_W;

   // frame tag kept with each line store word
   localparam int EPOCH_W        = 8;
   localparam int WORD_W         = EPOCH_W + ERROR_BITS;

   // datapath widths: pixel plus two errors, then the weighted products
   localparam int SUM_W          = ERROR_BITS + 2;
   localparam int PROD_W         = SUM_W + 3;
   localparam int ACC_W          = PROD_W + 1;

   localparam int MIN_ROW_LENGTH = 3;
   localparam int MIN_ROW_COUNT  = 3;
   localparam int DIV_SHIFT      = 4;
   localparam int DIV_BIAS       = 15;

   localparam logic [ROW_LENGTH_W-1:0] ROW_LENGTH_RESET = ROW_LENGTH_W'(640);
   localparam logic [ROW_COUNT_W-1:0]  ROW_COUNT_RESET  = ROW_COUNT_W'(480);
   localparam logic [THRESHOLD_W-1:0]  THRESHOLD_RESET  = THRESHOLD_W'(128);

   localparam logic [GRAY_W-1:0] GRAY_WHITE = GRAY_W'(255);
   localparam logic [GRAY_W-1:0] GRAY_BLACK = GRAY_W'(0);

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_LENGTH = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_COUNT  = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD  = CSR_INDEX_W'(2);

   typedef logic [ADDR_W-1:0]              addr_type;
   typedef logic [EPOCH_W-1:0]             epoch_type;
   typedef logic [WORD_W-1:0]              word_type;
   typedef logic signed [ERROR_BITS-1:0]   err_type;

   localparam epoch_type EPOCH_LAST = {EPOCH_W{1'b1}};
   localparam addr_type  ADDR_LAST  = ADDR_W'(MAX_ROW_LENGTH - 1);

   localparam logic signed [ACC_W-1:0] ERR_HI = ACC_W'(2 ** (ERROR_BITS - 1) - 1);
   localparam logic signed [ACC_W-1:0] ERR_LO = ACC_W'(-(2 ** (ERROR_BITS - 1)));

   // what one pixel does, by its place in the frame
   typedef enum logic [2:0] {
      MODE_ROW0,
      MODE_PASS,
      MODE_LEFT,
      MODE_RIGHT,
      MODE_INNER
   } mode_type;

   typedef enum logic {
      CTRL_CLEAR,
      CTRL_RUN
   } ctrl_state_type;

   typedef struct packed {
      logic [GRAY_W-1:0]      gray;
      addr_type               x;
      mode_type               mode;
      logic                   frame_end;
      epoch_type              epoch;
      logic [THRESHOLD_W-1:0] threshold;
   } pix_item_type;

   typedef struct packed {
      logic     en;
      addr_type addr;
      word_type data;
   } mem_wr_type;

   // divide by 16, rounding toward zero
   function automatic logic signed [PROD_W-1:0] div16_trunc(
      input logic signed [PROD_W-1:0] v
   );
      logic signed [PROD_W-1:0] bias;
      bias = (v < 0) ? PROD_W'(DIV_BIAS) : '0;
      return (v + bias) >>> DIV_SHIFT;
   endfunction

   function automatic err_type sat_err(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] c;
      c = v;
      if (v > ERR_HI) c = ERR_HI;
      if (v < ERR_LO) c = ERR_LO;
      return ERROR_BITS'(c);
   endfunction

endpackage

>>> rtl/core/edh_req_if.sv
interface edh_req_if;
   logic                        valid;
   logic                        ready;
   logic [edh_pkg::GRAY_W-1:0]  gray_in;
   logic                        frame_start;

   modport source (output valid, output gray_in, output frame_start, input ready);
   modport sink   (input valid, input gray_in, input frame_start, output ready);
endinterface

>>> rtl/core/edh_rsp_if.sv
interface edh_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [edh_pkg::GRAY_W-1:0]  gray_out;
   logic                        frame_end;

   modport source (output valid, output gray_out, output frame_end, input ready);
   modport sink   (input valid, input gray_out, input frame_end, output ready);
endinterface

>>> rtl/core/edh_csr_if.sv
interface edh_csr_if;
   logic                              valid;
   logic                              ready;
   logic [edh_pkg::CSR_INDEX_W-1:0]   index;
   logic [edh_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/error_diffusion_halftone_top.sv
// floyd-steinberg halftoning, one pixel out per gray pixel in, binary for inner pixels
// path: a request word goes through the stage 1 register, with its line store read,
// then the output register; throughput: one word per cycle while the result side is ready
// reset (synchronous): config back to 640 x 480, threshold 128, then a
// clearing pass over the 2048-entry line store with req ready low;
// it reruns at the 256th frame start, then every 255th, once stage 1 is empty
module error_diffusion_halftone_top (
   input logic        clock,
   input logic        reset,
   edh_req_if.sink    req_chan,
   edh_rsp_if.source  rsp_chan,
   edh_csr_if.sink    csr_chan
);
   import edh_pkg::*;

   // stage 1 handoff between position logic and error datapath
   logic          s1_valid;
   logic          s1_advance;
   pix_item_type  s1_item;

   // line store ports
   logic          rd_en;
   addr_type      rd_addr;
   word_type      rd_word;
   mem_wr_type    diff_wr;
   mem_wr_type    mem_wr;

   // front end: config registers, frame position, frame tag, clearing pass;
   // it issues the line store read for the pixel it accepts
   edh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .csr_chan   (csr_chan),
      .s1_advance (s1_advance),
      .diff_wr    (diff_wr),
      .s1_valid   (s1_valid),
      .s1_item    (s1_item),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .mem_wr     (mem_wr)
   );

   // line store: one error per column for the row below, tagged with the
   // frame it was written in so a stale tag reads as zero
   edh_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_ROW_LENGTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (mem_wr.en),
      .wr_addr (mem_wr.addr),
      .wr_data (mem_wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   // error datapath: threshold, 7/3/5/1 split, carries, output register;
   // it writes back the below-left error of the pixel it finishes (a row 0 pixel
   // zeroes its own column), never the column read for a next pixel of the same frame
   edh_diffuse u_diffuse (
      .clock      (clock),
      .reset      (reset),
      .s1_valid   (s1_valid),
      .s1_item    (s1_item),
      .rd_word    (rd_word),
      .s1_advance (s1_advance),
      .diff_wr    (diff_wr),
      .rsp_chan   (rsp_chan)
   );

endmodule

>>> rtl/core/edh_ram.sv
module edh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/edh_front.sv
module edh_front (
   input  logic                  clock,
   input  logic                  reset,
   edh_req_if.sink               req_chan,
   edh_csr_if.sink               csr_chan,
   input  logic                  s1_advance,
   input  edh_pkg::mem_wr_type   diff_wr,
   output logic                  s1_valid,
   output edh_pkg::pix_item_type s1_item,
   output logic                  rd_en,
   output edh_pkg::addr_type     rd_addr,
   output edh_pkg::mem_wr_type   mem_wr
);
   import edh_pkg::*;

   logic [ROW_LENGTH_W-1:0] row_length_ff, row_length_in;
   logic [ROW_COUNT_W-1:0]  row_count_ff, row_count_in;
   logic [THRESHOLD_W-1:0]  threshold_ff, threshold_in;

   ctrl_state_type          state_ff, state_in;
   addr_type                sweep_ff, sweep_in;
   epoch_type               epoch_ff, epoch_in;
   addr_type                col_ff, col_in;
   logic [ROW_COUNT_W-1:0]  row_ff, row_in;
   logic                    s1_valid_ff, s1_valid_in;
   pix_item_type            s1_item_ff, s1_item_in;

   logic [LEN_W-1:0]        len_raw, len;
   logic [ROW_COUNT_W-1:0]  rows;
   addr_type                x_cur, x_eff;
   logic [ROW_COUNT_W-1:0]  y_cur;
   logic                    last_col, last_row;
   logic                    slot_free, wrap_hold, accept, sweep_done;
   logic                    sweeping;
   mode_type                mode;

   // configuration
   assign csr_chan.ready = 1'b1;

   always_comb begin
      row_length_in = row_length_ff;
      row_count_in  = row_count_ff;
      threshold_in  = threshold_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_ROW_LENGTH: row_length_in = csr_chan.data[ROW_LENGTH_W-1:0];
            CSR_ROW_COUNT:  row_count_in  = csr_chan.data[ROW_COUNT_W-1:0];
            CSR_THRESHOLD:  threshold_in  = csr_chan.data[THRESHOLD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // effective frame size
   always_comb begin
      len_raw = LEN_W'(row_length_ff);
      if (len_raw < LEN_W'(MIN_ROW_LENGTH)) begin
         len = LEN_W'(MIN_ROW_LENGTH);
      end else if (len_raw > LEN_W'(MAX_ROW_LENGTH)) begin
         len = LEN_W'(MAX_ROW_LENGTH);
      end else begin
         len = len_raw;
      end
      rows = (row_count_ff < ROW_COUNT_W'(MIN_ROW_COUNT)) ?
             ROW_COUNT_W'(MIN_ROW_COUNT) : row_count_ff;
   end

   // position of the incoming pixel
   always_comb begin
      x_cur    = req_chan.frame_start ? '0 : col_ff;
      y_cur    = req_chan.frame_start ? '0 : row_ff;
      last_col = (LEN_W'(x_cur) + 1'b1) >= len;
      last_row = ({1'b0, y_cur} + 1'b1) >= {1'b0, rows};
      x_eff    = last_col ? ADDR_W'(len - 1'b1) : x_cur;
      if (y_cur == '0) begin
         mode = MODE_ROW0;
      end else if (last_row) begin
         mode = MODE_PASS;
      end else if (x_eff == '0) begin
         mode = MODE_LEFT;
      end else if (last_col) begin
         mode = MODE_RIGHT;
      end else begin
         mode = MODE_INNER;
      end
   end

   // a frame start with the tag space used up waits for a clearing pass
   assign slot_free  = !s1_valid_ff || s1_advance;
   assign wrap_hold  = req_chan.frame_start && (epoch_ff == EPOCH_LAST);
   assign sweep_done = (sweep_ff == ADDR_LAST);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CTRL_CLEAR: begin
            if (sweep_done) state_in = CTRL_RUN;
         end
         CTRL_RUN: begin
            if (req_chan.valid && wrap_hold && !s1_valid_ff) state_in = CTRL_CLEAR;
         end
         default: state_in = CTRL_CLEAR;
      endcase
   end

   // state outputs
   always_comb begin
      sweeping       = 1'b0;
      req_chan.ready = 1'b0;
      case (state_ff)
         CTRL_CLEAR: sweeping       = 1'b1;
         CTRL_RUN:   req_chan.ready = slot_free && !wrap_hold;
         default:    sweeping       = 1'b0;
      endcase
   end

   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      sweep_in    = sweeping ? (sweep_done ? '0 : sweep_ff + 1'b1) : '0;
      epoch_in    = epoch_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      s1_valid_in = accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);
      s1_item_in  = s1_item_ff;
      if (sweeping && sweep_done) begin
         epoch_in = '0;
      end
      if (accept) begin
         if (req_chan.frame_start) epoch_in = epoch_ff + 1'b1;
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : y_cur + 1'b1;
         end else begin
            col_in = x_eff + 1'b1;
            row_in = y_cur;
         end
         s1_item_in.gray      = req_chan.gray_in;
         s1_item_in.x         = x_eff;
         s1_item_in.mode      = mode;
         s1_item_in.frame_end = last_col && last_row;
         s1_item_in.epoch     = req_chan.frame_start ? epoch_ff + 1'b1 : epoch_ff;
         s1_item_in.threshold = threshold_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= ROW_LENGTH_RESET;
         row_count_ff  <= ROW_COUNT_RESET;
         threshold_ff  <= THRESHOLD_RESET;
         state_ff      <= CTRL_CLEAR;
         sweep_ff      <= '0;
         epoch_ff      <= '0;
         col_ff        <= '0;
         row_ff        <= '0;
         s1_valid_ff   <= 1'b0;
      end else begin
         row_length_ff <= row_length_in;
         row_count_ff  <= row_count_in;
         threshold_ff  <= threshold_in;
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         epoch_ff      <= epoch_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         s1_valid_ff   <= s1_valid_in;
      end
      s1_item_ff <= s1_item_in;
   end

   assign rd_en    = accept;
   assign rd_addr  = x_eff;
   assign s1_valid = s1_valid_ff;
   assign s1_item  = s1_item_ff;

   // clearing pass owns the write port while it runs
   always_comb begin
      if (sweeping) begin
         mem_wr.en   = 1'b1;
         mem_wr.addr = sweep_ff;
         mem_wr.data = '0;
      end else begin
         mem_wr = diff_wr;
      end
   end

endmodule

>>> rtl/core/edh_diffuse.sv
module edh_diffuse (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  s1_valid,
   input  edh_pkg::pix_item_type s1_item,
   input  edh_pkg::word_type     rd_word,
   output logic                  s1_advance,
   output edh_pkg::mem_wr_type   diff_wr,
   edh_rsp_if.source             rsp_chan
);
   import edh_pkg::*;

   err_type                  rc_ff, rc_in;
   err_type                  pbl_ff, pbl_in;
   err_type                  pb_ff, pb_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [GRAY_W-1:0]        gray_ff, gray_in_w;
   logic                     frame_end_ff;

   err_type                  below;
   logic signed [SUM_W-1:0]  sum, q;
   logic signed [PROD_W-1:0] q_w, q3, q5, q7;
   err_type                  rc_new, bl_new, pbl_new, pb_new;
   logic                     white;

   assign s1_advance = s1_valid && (!rsp_valid_ff || rsp_chan.ready);

   // error math for an interior pixel
   always_comb begin
      below = (rd_word[WORD_W-1 -: EPOCH_W] == s1_item.epoch) ?
              err_type'(rd_word[ERROR_BITS-1:0]) : '0;
      sum   = $signed({{(SUM_W - GRAY_W){1'b0}}, s1_item.gray})
              + SUM_W'(below) + SUM_W'(rc_ff);
      white = sum >= $signed({{(SUM_W - THRESHOLD_W){1'b0}}, s1_item.threshold});
      q     = sum - (white ? $signed({{(SUM_W - GRAY_W){1'b0}}, GRAY_WHITE}) : '0);
      q_w   = PROD_W'(q);
      q3    = (q_w <<< 1) + q_w;
      q5    = (q_w <<< 2) + q_w;
      q7    = (q_w <<< 3) - q_w;
      rc_new  = sat_err(ACC_W'(div16_trunc(q7)));
      bl_new  = sat_err(ACC_W'(pbl_ff) + ACC_W'(div16_trunc(q3)));
      pbl_new = sat_err(ACC_W'(pb_ff) + ACC_W'(div16_trunc(q5)));
      pb_new  = sat_err(ACC_W'(div16_trunc(q_w)));
   end

   always_comb begin
      diff_wr.en   = 1'b0;
      diff_wr.addr = s1_item.x - 1'b1;
      diff_wr.data = {s1_item.epoch, bl_new};
      rc_in        = rc_ff;
      pbl_in       = pbl_ff;
      pb_in        = pb_ff;
      gray_in_w    = s1_item.gray;
      case (s1_item.mode)
         MODE_ROW0: begin
            diff_wr.en   = s1_advance;
            diff_wr.addr = s1_item.x;
            diff_wr.data = {s1_item.epoch, err_type'(0)};
         end
         MODE_PASS: begin
         end
         MODE_LEFT: begin
            if (s1_advance) begin
               rc_in  = '0;
               pbl_in = '0;
               pb_in  = '0;
            end
         end
         MODE_RIGHT: begin
            diff_wr.en   = s1_advance;
            diff_wr.data = {s1_item.epoch, pbl_ff};
            if (s1_advance) begin
               rc_in  = '0;
               pbl_in = '0;
               pb_in  = '0;
            end
         end
         MODE_INNER: begin
            diff_wr.en = s1_advance;
            gray_in_w  = white ? GRAY_WHITE : GRAY_BLACK;
            if (s1_advance) begin
               rc_in  = rc_new;
               pbl_in = pbl_new;
               pb_in  = pb_new;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = s1_advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rc_ff        <= '0;
         pbl_ff       <= '0;
         pb_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rc_ff        <= rc_in;
         pbl_ff       <= pbl_in;
         pb_ff        <= pb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (s1_advance) begin
         gray_ff      <= gray_in_w;
         frame_end_ff <= s1_item.frame_end;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.gray_out  = gray_ff;
   assign rsp_chan.frame_end = frame_end_ff;

endmodule

>>> dv/edh_halftone_checker.sv
module edh_halftone_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [edh_pkg::GRAY_W-1:0]      req_gray,
   input  logic                            req_frame_start,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [edh_pkg::GRAY_W-1:0]      rsp_gray,
   input  logic                            rsp_frame_end,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [edh_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [edh_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                              mismatch_count,
   output int                              results_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   import edh_pkg::*;

   localparam int REPORT_LIMIT = 10;
   localparam int ERR_CEIL     = 2 ** (ERROR_BITS - 1) - 1;
   localparam int ERR_FLOOR    = -(2 ** (ERROR_BITS - 1));

   typedef struct packed {
      logic [GRAY_W-1:0] gray;
      logic              frame_end;
   } halftone_word_type;

   // frame format as last written
   logic [ROW_LENGTH_W-1:0] fmt_len;
   logic [ROW_COUNT_W-1:0]  fmt_rows;
   logic [THRESHOLD_W-1:0]  fmt_thresh;

   // diffused error and raster position
   err_type     line_error [MAX_ROW_LENGTH];
   err_type     carry_right;
   err_type     below_left_sum;
   err_type     below_sum;
   int unsigned col_pos;
   int unsigned row_pos;

   halftone_word_type halftone_q [$];
   int                mismatches = 0;
   int                words_seen = 0;

   function automatic err_type clip_error(input int v);
      if (v > ERR_CEIL) return err_type'(ERR_CEIL);
      if (v < ERR_FLOOR) return err_type'(ERR_FLOOR);
      return err_type'(v);
   endfunction

   function automatic void clear_diffusion();
      foreach (line_error[i]) line_error[i] = '0;
      carry_right    = '0;
      below_left_sum = '0;
      below_sum      = '0;
   endfunction

   function automatic halftone_word_type dither_pixel(input logic [GRAY_W-1:0] pix,
                                                      input logic restart);
      int                span;
      int                rows;
      int                x;
      int                y;
      int                total;
      int                q;
      logic              at_last_col;
      logic              at_last_row;
      halftone_word_type res;
      span = int'(fmt_len);
      if (span < MIN_ROW_LENGTH) span = MIN_ROW_LENGTH;
      if (span > MAX_ROW_LENGTH) span = MAX_ROW_LENGTH;
      rows = (int'(fmt_rows) < MIN_ROW_COUNT) ? MIN_ROW_COUNT : int'(fmt_rows);
      if (restart) begin
         col_pos = 0;
         row_pos = 0;
         clear_diffusion();
      end
      x = int'(col_pos);
      y = int'(row_pos);
      at_last_col = (x + 1 >= span);
      at_last_row = (y + 1 >= rows);
      if (at_last_col) x = span - 1;
      res.gray = pix;
      if (y == 0) begin
         line_error[x] = '0;
      end else if (!at_last_row) begin
         if (x == 0) begin
            carry_right    = '0;
            below_left_sum = '0;
            below_sum      = '0;
         end else if (at_last_col) begin
            line_error[x-1] = below_left_sum;
            carry_right     = '0;
            below_left_sum  = '0;
            below_sum       = '0;
         end else begin
            total = int'(pix) + int'(line_error[x]) + int'(carry_right);
            res.gray = (total >= int'(fmt_thresh)) ? GRAY_WHITE : GRAY_BLACK;
            q = total - int'(res.gray);
            carry_right     = clip_error(q * 7 / 16);
            line_error[x-1] = clip_error(int'(below_left_sum) + q * 3 / 16);
            below_left_sum  = clip_error(int'(below_sum) + q * 5 / 16);
            below_sum       = clip_error(q / 16);
         end
      end
      res.frame_end = at_last_col && at_last_row;
      if (at_last_col) begin
         col_pos = 0;
         row_pos = at_last_row ? 0 : y + 1;
      end else begin
         col_pos = x + 1;
      end
      return res;
   endfunction

   task automatic flag_mismatch(input string what, input int want, input int got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("[%0t] word %0d: %s mismatch, expected %0d, got %0d",
                  $realtime, words_seen, what, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      halftone_word_type seen;
      halftone_word_type want;
      if (reset) begin
         fmt_len    = ROW_LENGTH_RESET;
         fmt_rows   = ROW_COUNT_RESET;
         fmt_thresh = THRESHOLD_RESET;
         clear_diffusion();
         col_pos = 0;
         row_pos = 0;
         halftone_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ROW_LENGTH: fmt_len    = csr_data[ROW_LENGTH_W-1:0];
               CSR_ROW_COUNT:  fmt_rows   = csr_data[ROW_COUNT_W-1:0];
               CSR_THRESHOLD:  fmt_thresh = csr_data[THRESHOLD_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            halftone_q.push_back(dither_pixel(req_gray, req_frame_start));
         end
         if (rsp_valid && rsp_ready) begin
            seen.gray      = rsp_gray;
            seen.frame_end = rsp_frame_end;
            if (halftone_q.size() == 0) begin
               flag_mismatch("unrequested word, gray_out", -1, int'(seen.gray));
            end else begin
               want = halftone_q.pop_front();
               if (seen.gray !== want.gray) begin
                  flag_mismatch("gray_out", int'(want.gray), int'(seen.gray));
               end
               if (seen.frame_end !== want.frame_end) begin
                  flag_mismatch("frame_end", int'(want.frame_end), int'(seen.frame_end));
               end
            end
            words_seen++;
         end
      end
      mismatch_count <= mismatches;
      results_owed   <= halftone_q.size();
   end

endmodule

>>> dv/error_diffusion_halftone_top_tb.sv
module error_diffusion_halftone_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import edh_pkg::*;

   localparam int CLK_PERIOD   = 10;
   localparam int RESET_CYCLES = 12;
   localparam int MAX_WAIT     = 18;     // longest gap or stall per word
   localparam int RANDOM_ITEMS = 600;    // storm words plus random phase words
   localparam int QUIET_LIMIT  = 20000;  // covers the line store clearing pass
   localparam int DRAIN_CYCLES = 8;      // extra wait after the last result comes back
   localparam int LONG_ROW     = 200;    // row length of the long frame
   localparam int BIG_TAIL     = 40;     // words of row 1 in the long frame
   localparam int STORM_WORDS  = 270;    // enough frame starts to wrap the tag
   localparam int PARTIAL_CAP  = 200;

   // 5 x 4 frame: border words pass, the six inner ones sit at the extremes or near 128
   localparam logic [GRAY_W-1:0] SHAPE_FRAME [20] = '{
      8'd255, 8'd0,   8'd255, 8'd1,   8'd254,
      8'd3,   8'd255, 8'd0,   8'd128, 8'd127,
      8'd200, 8'd129, 8'd130, 8'd1,   8'd250,
      8'd0,   8'd255, 8'd64,  8'd192, 8'd9
   };

   logic clock = 1'b0;
   logic reset;

   edh_req_if req_chan ();
   edh_rsp_if rsp_chan ();
   edh_csr_if csr_chan ();

   int mismatch_count;
   int results_owed;
   int req_gap_max   = 0;
   int rsp_stall_max = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   error_diffusion_halftone_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   edh_halftone_checker halftone_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_chan.valid),
      .req_ready       (req_chan.ready),
      .req_gray        (req_chan.gray_in),
      .req_frame_start (req_chan.frame_start),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_gray        (rsp_chan.gray_out),
      .rsp_frame_end   (rsp_chan.frame_end),
      .csr_valid       (csr_chan.valid),
      .csr_ready       (csr_chan.ready),
      .csr_index       (csr_chan.index),
      .csr_data        (csr_chan.data),
      .mismatch_count  (mismatch_count),
      .results_owed    (results_owed)
   );

   function automatic int draw_wait(input int ceiling);
      return (ceiling == 0) ? 0 : int'($urandom_range(0, ceiling));
   endfunction

   // half random gray, half the extremes, the threshold and the value just below it
   function automatic logic [GRAY_W-1:0] draw_gray(input logic [THRESHOLD_W-1:0] cut);
      case ($urandom_range(0, 7))
         0:       return GRAY_BLACK;
         1:       return GRAY_WHITE;
         2:       return cut;
         3:       return cut - 8'd1;
         default: return GRAY_W'($urandom);
      endcase
   endfunction

   // per phase: no idling, idling on one side, or on both
   task automatic pick_pacing();
      case ($urandom_range(0, 3))
         0: begin
            req_gap_max   = 0;
            rsp_stall_max = 0;
         end
         1: begin
            req_gap_max   = MAX_WAIT;
            rsp_stall_max = 0;
         end
         2: begin
            req_gap_max   = 0;
            rsp_stall_max = MAX_WAIT;
         end
         default: begin
            req_gap_max   = MAX_WAIT;
            rsp_stall_max = MAX_WAIT;
         end
      endcase
   endtask

   // one word; valid stays high for a back-to-back follower
   task automatic send_pixel(input logic [GRAY_W-1:0] gray, input logic restart);
      int gap;
      gap = draw_wait(req_gap_max);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.gray_in     <= gray;
      req_chan.frame_start <= restart;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // all three registers in one burst; unused upper data bits get noise
   task automatic program_format(input logic [ROW_LENGTH_W-1:0] len,
                                 input logic [ROW_COUNT_W-1:0]  rows,
                                 input logic [THRESHOLD_W-1:0]  thr);
      for (int slot = 0; slot < 3; slot++) begin
         case (slot)
            0: begin
               csr_chan.index <= CSR_ROW_LENGTH;
               csr_chan.data  <= {4'($urandom), len};
            end
            1: begin
               csr_chan.index <= CSR_ROW_COUNT;
               csr_chan.data  <= rows;
            end
            default: begin
               csr_chan.index <= CSR_THRESHOLD;
               csr_chan.data  <= {8'($urandom), thr};
            end
         endcase
         csr_chan.valid <= 1'b1;
         @(posedge clock);
         while (!csr_chan.ready) @(posedge clock);
      end
      csr_chan.valid <= 1'b0;
   endtask

   // every expected word back, then the pipe gets time to go quiet
   task automatic wait_drained();
      do @(posedge clock); while (results_owed != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // result side: a fresh stall before every word
   initial begin : result_sink
      int hold;
      forever begin
         hold = draw_wait(rsp_stall_max);
         if (hold > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
      end
   end

   // watchdog: too long without any handshake on any channel
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
             (csr_chan.valid && csr_chan.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : stimulus
      logic [ROW_LENGTH_W-1:0] len;
      logic [ROW_COUNT_W-1:0]  rows;
      logic [THRESHOLD_W-1:0]  thr;
      logic                    restart;
      int                      eff_len;
      int                      eff_rows;
      int                      frame_px;
      int                      span;
      int                      cut;
      int                      shape;
      int                      sent;
      int                      phase;

      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.gray_in     <= '0;
      req_chan.frame_start <= 1'b0;
      csr_chan.valid       <= 1'b0;
      csr_chan.index       <= CSR_ROW_LENGTH;
      csr_chan.data        <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset format 640 x 480: row 0 words come back untouched
      pick_pacing();
      send_pixel(GRAY_WHITE, 1'b1);
      send_pixel(GRAY_BLACK, 1'b0);
      send_pixel(8'd128, 1'b0);
      send_pixel(8'd77, 1'b0);
      req_chan.valid <= 1'b0;

      // one full 5 x 4 frame, then one word into the implicit next frame
      wait_drained();
      program_format(12'd5, 16'd4, 8'd128);
      pick_pacing();
      foreach (SHAPE_FRAME[i]) send_pixel(SHAPE_FRAME[i], i == 0);
      send_pixel(8'd200, 1'b0);
      req_chan.valid <= 1'b0;

      // long row: all of row 0 and a slice of row 1, full rate
      wait_drained();
      program_format(ROW_LENGTH_W'(LONG_ROW), 16'd3, 8'd128);
      req_gap_max   = 0;
      rsp_stall_max = 0;
      for (int k = 0; k < LONG_ROW + BIG_TAIL; k++) begin
         send_pixel(GRAY_W'($urandom), k == 0);
      end
      req_chan.valid <= 1'b0;

      // shrink the row under a position far past its end, no frame start
      wait_drained();
      program_format(12'd5, 16'd4, 8'd100);
      pick_pacing();
      for (int k = 0; k < 8; k++) send_pixel(draw_gray(8'd100), 1'b0);
      req_chan.valid <= 1'b0;

      // a run of frame starts, enough to wrap the line store frame tag
      sent = 0;
      pick_pacing();
      for (int k = 0; k < STORM_WORDS; k++) begin
         send_pixel(GRAY_W'($urandom), 1'b1);
         sent++;
      end
      req_chan.valid <= 1'b0;

      // random phases: a format, a pacing, then a few frames
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         case (phase)
            0: begin
               len = 12'd3;    rows = 16'd3;     thr = 8'd0;
            end
            1: begin
               len = 12'd0;    rows = 16'hFFFF;  thr = 8'd255;
            end
            2: begin
               len = 12'hFFF;  rows = 16'd1;     thr = 8'd1;
            end
            3: begin
               len = 12'd2;    rows = 16'd2;     thr = 8'd128;
            end
            default: begin
               case ($urandom_range(0, 9))
                  0:       len = ROW_LENGTH_W'($urandom_range(0, 2));
                  1:       len = ROW_LENGTH_W'($urandom_range(2049, 4095));
                  2:       len = 12'd3;
                  default: len = ROW_LENGTH_W'($urandom_range(4, 12));
               endcase
               case ($urandom_range(0, 9))
                  0:       rows = ROW_COUNT_W'($urandom_range(0, 2));
                  1:       rows = 16'hFFFF;
                  2:       rows = 16'd3;
                  default: rows = ROW_COUNT_W'($urandom_range(4, 8));
               endcase
               case ($urandom_range(0, 9))
                  0:       thr = 8'd0;
                  1:       thr = 8'd1;
                  2:       thr = 8'd255;
                  3:       thr = 8'd128;
                  default: thr = THRESHOLD_W'($urandom);
               endcase
            end
         endcase
         wait_drained();
         program_format(len, rows, thr);
         pick_pacing();

         eff_len  = (len < MIN_ROW_LENGTH) ? MIN_ROW_LENGTH :
                    (len > MAX_ROW_LENGTH) ? MAX_ROW_LENGTH : int'(len);
         eff_rows = (rows < MIN_ROW_COUNT) ? MIN_ROW_COUNT : int'(rows);
         frame_px = eff_len * eff_rows;

         repeat ($urandom_range(1, 3)) begin
            // shape 0: no frame start, 1: cut short, 2: restart midway,
            // 3: frame starts sprinkled at random, else a clean frame
            shape = $urandom_range(0, 9);
            span  = frame_px;
            if (span > PARTIAL_CAP) begin
               span = $urandom_range(20, 120);
            end else if (shape == 1) begin
               span = $urandom_range(1, span);
            end
            cut = (shape == 2) ? int'($urandom_range(1, span - 1)) : -1;
            for (int k = 0; k < span; k++) begin
               restart = ((k == 0) && (shape != 0)) || (k == cut) ||
                         ((shape == 3) && ($urandom_range(0, 3) == 0));
               send_pixel(draw_gray(thr), restart);
               sent++;
            end
         end
         req_chan.valid <= 1'b0;
         phase++;
      end

      wait_drained();
      if (mismatch_count == 0 && results_owed == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/edh_pkg.sv
rtl/core/edh_req_if.sv
rtl/core/edh_rsp_if.sv
rtl/core/edh_csr_if.sv
rtl/core/edh_ram.sv
rtl/core/edh_front.sv
rtl/core/edh_diffuse.sv
rtl/core/error_diffusion_halftone_top.sv
dv/edh_halftone_checker.sv
dv/error_diffusion_halftone_top_tb.sv
